FILE: sv/mpe_pkg.sv
`timescale 1ns / 1ps
// Package for the mouse packet event decoder: flag bits, event kinds and the
// packet descriptor passed from the front end to the event sequencer. No dependencies.
package mpe_pkg;

    // Bit positions in the flags byte
    localparam int FLAG_LEFT_BIT   = 0;
    localparam int FLAG_RIGHT_BIT  = 1;
    localparam int FLAG_MIDDLE_BIT = 2;
    localparam int FLAG_XSIGN_BIT  = 4;
    localparam int FLAG_YSIGN_BIT  = 5;
    localparam int FLAG_XOVER_BIT  = 6;
    localparam int FLAG_YOVER_BIT  = 7;
    localparam logic [7:0] MOVE_FLAGS_MASK = 8'hF0;

    // Default depth of the packet queue
    localparam int PKT_FIFO_DEPTH = 4;

    // Register map
    localparam logic CFG_IDX_WHEEL_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        EV_LDOWN = 3'd0,
        EV_LUP   = 3'd1,
        EV_MDOWN = 3'd2,
        EV_MUP   = 3'd3,
        EV_RDOWN = 3'd4,
        EV_RUP   = 3'd5,
        EV_WHEEL = 3'd6,
        EV_MOVE  = 3'd7
    } event_kind_t;

    // Pending-event bits, in emission order (lowest goes first)
    localparam int EVB_LEFT   = 0;
    localparam int EVB_MIDDLE = 1;
    localparam int EVB_RIGHT  = 2;
    localparam int EVB_WHEEL  = 3;
    localparam int EVB_MOVE   = 4;
    localparam int EV_BITS    = 5;

    // One decoded packet waiting for its events to be sent
    typedef struct packed {
        logic [EV_BITS-1:0] ev_mask;
        logic               btn_left;
        logic               btn_middle;
        logic               btn_right;
        logic signed [7:0]  wheel_delta;
        logic signed [8:0]  move_x;
        logic signed [8:0]  move_y;
    } pkt_desc_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: sv/mpe_front.sv
`timescale 1ns / 1ps
// Front end: collects mouse bytes into packets, compares each packet with
// the previous one and queues a descriptor of the changes. Uses mpe_pkg.
module mpe_front
    import mpe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wheel_enable,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] data_byte
    input  fifo_stat_t fifo_stat,
    output logic       push,
    output pkt_desc_t  push_desc
);

    logic [1:0] byte_pos_reg, byte_pos_next;
    logic [7:0] pkt0_reg, pkt1_reg, pkt2_reg;
    logic [7:0] prev_reg [4];
    logic [7:0] p [4];
    logic       accept, complete;
    logic [EV_BITS-1:0] mask;

    // Hold input whenever the queue cannot take another packet
    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign complete = accept && ((byte_pos_reg == 2'd2 && !wheel_enable) ||
                                 byte_pos_reg == 2'd3);

    // Packet as it stands with the incoming byte
    always_comb begin
        p[0] = pkt0_reg;
        p[1] = pkt1_reg;
        p[2] = (byte_pos_reg == 2'd2) ? s_tdata : pkt2_reg;
        p[3] = (byte_pos_reg == 2'd3) ? s_tdata : 8'd0;
    end

    function automatic logic [8:0] motion(input logic over, input logic sign,
                                          input logic [7:0] val);
        logic [8:0] r;
        if (over) begin
            r = 9'd0;
        end else if (sign) begin
            r = (val == 8'd0) ? 9'd0 : {1'b1, val};
        end else begin
            r = {1'b0, val};
        end
        return r;
    endfunction

    // Change detection
    always_comb begin
        mask = '0;
        mask[EVB_LEFT]   = p[0][FLAG_LEFT_BIT]   != prev_reg[0][FLAG_LEFT_BIT];
        mask[EVB_MIDDLE] = p[0][FLAG_MIDDLE_BIT] != prev_reg[0][FLAG_MIDDLE_BIT];
        mask[EVB_RIGHT]  = p[0][FLAG_RIGHT_BIT]  != prev_reg[0][FLAG_RIGHT_BIT];
        mask[EVB_WHEEL]  = p[3] != prev_reg[3];
        mask[EVB_MOVE]   = ((p[0] & MOVE_FLAGS_MASK) != (prev_reg[0] & MOVE_FLAGS_MASK)) ||
                           (p[1] != prev_reg[1]) || (p[2] != prev_reg[2]);
    end

    always_comb begin
        push_desc.ev_mask     = mask;
        push_desc.btn_left    = p[0][FLAG_LEFT_BIT];
        push_desc.btn_middle  = p[0][FLAG_MIDDLE_BIT];
        push_desc.btn_right   = p[0][FLAG_RIGHT_BIT];
        push_desc.wheel_delta = p[3];
        push_desc.move_x      = motion(p[0][FLAG_XOVER_BIT], p[0][FLAG_XSIGN_BIT], p[1]);
        push_desc.move_y      = motion(p[0][FLAG_YOVER_BIT], p[0][FLAG_YSIGN_BIT], p[2]);
    end

    // Identical packets produce nothing
    assign push = complete && (mask != '0);

    // Byte position
    always_comb begin
        byte_pos_next = byte_pos_reg;
        if (accept) begin
            byte_pos_next = complete ? 2'd0 : byte_pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= 2'd0;
            for (int i = 0; i < 4; i++) begin
                prev_reg[i] <= 8'd0;
            end
        end else begin
            byte_pos_reg <= byte_pos_next;
            if (complete) begin
                for (int i = 0; i < 4; i++) begin
                    prev_reg[i] <= p[i];
                end
            end
        end
    end

    // Packet bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            unique case (byte_pos_reg)
                2'd0:    pkt0_reg <= s_tdata;
                2'd1:    pkt1_reg <= s_tdata;
                2'd2:    pkt2_reg <= s_tdata;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/mpe_fifo.sv
`timescale 1ns / 1ps
// Small queue of packet descriptors between front end and event sequencer.
// Uses mpe_pkg.
module mpe_fifo
    import mpe_pkg::*;
#(
    parameter int DEPTH = PKT_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pkt_desc_t  push_desc,
    input  logic       pop,
    output pkt_desc_t  head,
    output fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pkt_desc_t      mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: sv/mpe_back.sv
`timescale 1ns / 1ps
// Event sequencer: walks the pending changes of the queue head, one event per
// cycle unless m_tready stalls, into a registered output stage. Uses mpe_pkg.
module mpe_back
    import mpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pkt_desc_t   head,
    input  fifo_stat_t  fifo_stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic [EV_BITS-1:0] done_reg;
    logic [EV_BITS-1:0] remaining, sel, rem_after;
    logic               out_valid_reg;
    event_kind_t        kind_reg, kind;
    logic signed [8:0]  move_x_reg, move_x;
    logic signed [8:0]  move_y_reg, move_y;
    logic signed [7:0]  wheel_reg, wheel;
    logic               last_reg;
    logic               load;

    assign remaining = head.ev_mask & ~done_reg;
    assign load      = !fifo_stat.empty && (!out_valid_reg || m_tready);
    assign rem_after = remaining & ~sel;
    assign pop       = load && (rem_after == '0);

    // Pick the earliest pending change
    always_comb begin
        sel    = '0;
        kind   = EV_MOVE;
        move_x = '0;
        move_y = '0;
        wheel  = '0;
        priority if (remaining[EVB_LEFT]) begin
            sel[EVB_LEFT] = 1'b1;
            kind = head.btn_left ? EV_LDOWN : EV_LUP;
        end else if (remaining[EVB_MIDDLE]) begin
            sel[EVB_MIDDLE] = 1'b1;
            kind = head.btn_middle ? EV_MDOWN : EV_MUP;
        end else if (remaining[EVB_RIGHT]) begin
            sel[EVB_RIGHT] = 1'b1;
            kind = head.btn_right ? EV_RDOWN : EV_RUP;
        end else if (remaining[EVB_WHEEL]) begin
            sel[EVB_WHEEL] = 1'b1;
            kind  = EV_WHEEL;
            wheel = head.wheel_delta;
        end else begin
            sel[EVB_MOVE] = 1'b1;
            kind   = EV_MOVE;
            move_x = head.move_x;
            move_y = head.move_y;
        end
    end

    // Progress through the head packet and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                done_reg      <= pop ? '0 : (done_reg | sel);
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= kind;
            move_x_reg <= move_x;
            move_y_reg <= move_y;
            wheel_reg  <= wheel;
            last_reg   <= (rem_after == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, wheel_reg, move_y_reg, move_x_reg};

endmodule

FILE: sv/mouse_packet_event_decoder.sv
`timescale 1ns / 1ps
// Mouse packet event decoder top level. A packet's descriptor is queued at the edge that
// accepts its final byte; its events then leave through the registered output stage.
// Throughput: one byte per cycle in, one event per cycle out while m_tready is high.
// s_tready drops only while the packet queue (FIFO_DEPTH entries) is full.
// Reset: synchronous active-low aresetn clears position, previous packet,
// queue, output valid and wheel_enable. Uses mpe_pkg, mpe_front, mpe_fifo, mpe_back.
module mouse_packet_event_decoder
    import mpe_pkg::*;
#(
    parameter int FIFO_DEPTH = PKT_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Mouse bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // Events
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [8:0] move_x, [17:9] move_y, [25:18] wheel_delta
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast    // last_event
);

    logic       wheel_enable_reg;
    logic       push, pop;
    pkt_desc_t  push_desc, head;
    fifo_stat_t fifo_stat;

    // Register file
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_enable_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == CFG_IDX_WHEEL_ENABLE) begin
            wheel_enable_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == CFG_IDX_WHEEL_ENABLE) ? {31'd0, wheel_enable_reg} : 32'd0;

    mpe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wheel_enable (wheel_enable_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .push_desc    (push_desc)
    );

    mpe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    mpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/mpe_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the mouse packet event decoder, bound to the top level.
// Uses mpe_pkg.
module mpe_checker
    import mpe_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled event transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("event changed while stalled");

    // Motion fields are zero except on move events
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_MOVE |-> m_tdata[17:0] == 18'd0)
        else $error("motion on a non-move event");

    // Wheel field is zero except on wheel events
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_WHEEL |-> m_tdata[25:18] == 8'd0)
        else $error("wheel delta on a non-wheel event");

    // Move is always the final event of its packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_MOVE |-> m_tlast)
        else $error("move event not marked last");

    // Pad bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:26] == 6'd0)
        else $error("nonzero pad bits");

endmodule

bind mouse_packet_event_decoder mpe_checker u_mpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: sim/mouse_packet_event_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for mouse_packet_event_decoder: drives mouse bytes and
// register writes, predicts the event stream and compares every event transaction.
// Depends on mpe_pkg and the mouse_packet_event_decoder RTL.
module mouse_packet_event_decoder_test;
    import mpe_pkg::*;

    localparam int REG_IDX_UNMAPPED = 1;
    localparam logic [2:0] ADDR_WHEEL_ENABLE = {CFG_IDX_WHEEL_ENABLE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = 3'(REG_IDX_UNMAPPED * 4);
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 155;
    localparam int PRESSURE_BYTES = 45;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        event_kind_t       kind;
        logic signed [8:0] move_x;
        logic signed [8:0] move_y;
        logic signed [7:0] wheel_delta;
        logic              last_event;
    } mouse_event_t;

    // Directed plan: a byte or a register write, with how its events are known
    typedef enum logic [1:0] {ROW_BYTE, ROW_REG} row_op_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} row_exp_t;

    typedef struct packed {
        row_op_t           op;
        logic [2:0]        reg_addr;
        logic [7:0]        value;
        row_exp_t          exp_mode;
        event_kind_t       kind;
        logic signed [8:0] move_x;
        logic signed [8:0] move_y;
        logic signed [7:0] wheel_delta;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [8:0] move_x, [17:9] move_y, [25:18] wheel_delta
    logic [2:0]  m_tuser;   // [2:0] event_kind
    logic        m_tlast;   // last_event

    // Decoder shadow state
    logic [1:0]   rx_pos;
    logic [7:0]   cur_pkt [4];
    logic [7:0]   prev_pkt [4];
    logic         wheel_mode;
    mouse_event_t fresh_events [5];
    int           fresh_count;

    mouse_event_t pending_events [$];
    plan_row_t    plan [$];
    int           fail_count;
    logic         hold_req;
    logic         tx_burst;
    logic         rx_burst;

    mouse_packet_event_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------

    function automatic logic signed [8:0] motion(logic over, logic sgn, logic [7:0] v);
        if (over)
            return 9'sd0;
        if (sgn)
            return (v == 8'h00) ? 9'sd0 : {1'b1, v};
        return {1'b0, v};
    endfunction

    function void add_event(event_kind_t kind, logic signed [8:0] mx,
                            logic signed [8:0] my, logic signed [7:0] wd);
        fresh_events[fresh_count] = '{kind, mx, my, wd, 1'b0};
        fresh_count++;
    endfunction

    function void note_button(int bit_idx, event_kind_t down_kind, event_kind_t up_kind);
        if (cur_pkt[0][bit_idx] != prev_pkt[0][bit_idx])
            add_event(cur_pkt[0][bit_idx] ? down_kind : up_kind, 9'sd0, 9'sd0, 8'sd0);
    endfunction

    // Compare the finished packet with the previous one, in emission order
    function void decode_packet();
        note_button(FLAG_LEFT_BIT, EV_LDOWN, EV_LUP);
        note_button(FLAG_MIDDLE_BIT, EV_MDOWN, EV_MUP);
        note_button(FLAG_RIGHT_BIT, EV_RDOWN, EV_RUP);
        if (cur_pkt[3] != prev_pkt[3])
            add_event(EV_WHEEL, 9'sd0, 9'sd0, cur_pkt[3]);
        if ((cur_pkt[0] & MOVE_FLAGS_MASK) != (prev_pkt[0] & MOVE_FLAGS_MASK) ||
            cur_pkt[1] != prev_pkt[1] || cur_pkt[2] != prev_pkt[2])
            add_event(EV_MOVE,
                      motion(cur_pkt[0][FLAG_XOVER_BIT], cur_pkt[0][FLAG_XSIGN_BIT],
                             cur_pkt[1]),
                      motion(cur_pkt[0][FLAG_YOVER_BIT], cur_pkt[0][FLAG_YSIGN_BIT],
                             cur_pkt[2]),
                      8'sd0);
        if (fresh_count > 0)
            fresh_events[fresh_count - 1].last_event = 1'b1;
        prev_pkt = cur_pkt;
    endfunction

    // Take one accepted byte; returns the number of events it causes
    function int mouse_byte_events(logic [7:0] b);
        fresh_count = 0;
        cur_pkt[rx_pos] = b;
        if (rx_pos == 2'd2 && !wheel_mode) begin
            // three-byte packet: wheel byte counts as zero
            cur_pkt[3] = 8'h00;
            rx_pos = 2'd0;
            decode_packet();
        end else if (rx_pos == 2'd3) begin
            rx_pos = 2'd0;
            decode_packet();
        end else begin
            rx_pos = rx_pos + 2'd1;
        end
        return fresh_count;
    endfunction

    function void queue_events(int n);
        for (int i = 0; i < n; i++)
            pending_events.push_back(fresh_events[i]);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic plan_row_t row_byte(logic [7:0] b, row_exp_t mode);
        return '{ROW_BYTE, 3'd0, b, mode, EV_LDOWN, 9'sd0, 9'sd0, 8'sd0};
    endfunction

    function automatic plan_row_t row_event(logic [7:0] b, event_kind_t kind,
                                            logic signed [8:0] mx, logic signed [8:0] my,
                                            logic signed [7:0] wd);
        return '{ROW_BYTE, 3'd0, b, EXP_ONE, kind, mx, my, wd};
    endfunction

    function automatic plan_row_t row_reg(logic [2:0] addr, logic [7:0] v);
        return '{ROW_REG, addr, v, EXP_NONE, EV_LDOWN, 9'sd0, 9'sd0, 8'sd0};
    endfunction

    // Random byte shaped by its slot in the packet, often repeating the last packet
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        case (rx_pos)
            2'd0: begin
                if (r < 2) return prev_pkt[0];
                if (r < 4) return prev_pkt[0] ^ (8'h01 << $urandom_range(0, 2));
                if (r == 4) return prev_pkt[0] ^ (8'h01 << $urandom_range(4, 7));
                return 8'($urandom);
            end
            2'd3: begin
                if (r < 4) return prev_pkt[3];
                if (r == 4) return 8'h80;
                if (r == 5) return 8'h7F;
                return 8'($urandom);
            end
            default: begin
                if (r < 3) return prev_pkt[rx_pos];
                if (r == 3) return 8'h00;
                if (r == 4) return 8'hFF;
                return 8'($urandom);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and let every expected event and any in-flight byte drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((addr >> 2) == CFG_IDX_WHEEL_ENABLE)
            wheel_mode = data[0];
    endtask

    // ---------------- event checking ----------------

    function void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        mouse_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("event transaction with none expected: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", int'(want.kind), int'(m_tuser));
                check_field("move_x", int'(want.move_x), int'($signed(m_tdata[8:0])));
                check_field("move_y", int'(want.move_y), int'($signed(m_tdata[17:9])));
                check_field("wheel_delta", int'(want.wheel_delta),
                            int'($signed(m_tdata[25:18])));
                check_field("last_event", int'(want.last_event), int'(m_tlast));
                check_field("tdata_pad", 0, int'(m_tdata[31:26]));
            end
        end
    end

    // Event sink: random stalls, bursts, and one long hold-off to back up the queue
    initial begin
        int  gap;
        bit  held;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (!held && hold_req) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("mouse_packet_event_decoder: mismatch");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin
        int         n;
        int         sent;
        int         phase_len;
        logic [7:0] b;
        plan_row_t  row;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        tx_burst = 1'b0;
        hold_req = 1'b0;
        fail_count = 0;
        rx_pos     = 2'd0;
        wheel_mode = 1'b0;
        for (int i = 0; i < 4; i++) begin
            cur_pkt[i]  = 8'h00;
            prev_pkt[i] = 8'h00;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // First packet after reset, three-byte mode
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'h05, EXP_NONE));
        plan.push_back(row_event(8'h03, EV_MOVE, 9'sd5, 9'sd3, 8'sd0));
        // X overflow, and Y sign set with a zero byte: both give zero
        plan.push_back(row_byte(8'h70, EXP_NONE));
        plan.push_back(row_byte(8'hFF, EXP_NONE));
        plan.push_back(row_event(8'h00, EV_MOVE, 9'sd0, 9'sd0, 8'sd0));
        // All buttons down, most negative motion
        plan.push_back(row_byte(8'h37, EXP_NONE));
        plan.push_back(row_byte(8'h01, EXP_NONE));
        plan.push_back(row_byte(8'h01, EXP_MODEL));
        // Wheel mode: all buttons up, wheel minimum, largest motion (five events)
        plan.push_back(row_reg(ADDR_WHEEL_ENABLE, 8'd1));
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'hFF, EXP_NONE));
        plan.push_back(row_byte(8'hFF, EXP_NONE));
        plan.push_back(row_byte(8'h80, EXP_MODEL));
        // Wheel maximum only
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'hFF, EXP_NONE));
        plan.push_back(row_byte(8'hFF, EXP_NONE));
        plan.push_back(row_event(8'h7F, EV_WHEEL, 9'sd0, 9'sd0, 8'sd127));
        // Mode dropped after the third byte: the packet still takes four bytes
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_reg(ADDR_WHEEL_ENABLE, 8'd0));
        plan.push_back(row_byte(8'h00, EXP_MODEL));
        // Write to an unmapped register is ignored; repeated packet gives nothing
        plan.push_back(row_reg(ADDR_UNMAPPED, 8'd1));
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'h00, EXP_NONE));
        plan.push_back(row_byte(8'h00, EXP_NONE));

        foreach (plan[i]) begin
            row = plan[i];
            if (row.op == ROW_REG) begin
                write_reg(row.reg_addr, {24'd0, row.value});
            end else begin
                send_byte(row.value);
                n = mouse_byte_events(row.value);
                case (row.exp_mode)
                    EXP_MODEL: queue_events(n);
                    EXP_ONE:   pending_events.push_back('{row.kind, row.move_x, row.move_y,
                                                          row.wheel_delta, 1'b1});
                    default:   ;
                endcase
            end
        end

        // Random phases; boundaries fall mid-packet as often as not.
        // The first phase is long and runs while the sink holds off.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            write_reg(ADDR_WHEEL_ENABLE, $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                write_reg(ADDR_UNMAPPED, $urandom);
            if (sent == 0) begin
                phase_len = PRESSURE_BYTES;
                hold_req  = 1'b1;
            end else begin
                phase_len = $urandom_range(15, 45);
            end
            if (phase_len > RANDOM_BYTES - sent)
                phase_len = RANDOM_BYTES - sent;
            repeat (phase_len) begin
                b = pick_byte();
                send_byte(b);
                queue_events(mouse_byte_events(b));
                sent++;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("mouse_packet_event_decoder: match");
        else
            $display("mouse_packet_event_decoder: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mpe_pkg.sv
sv/mpe_front.sv
sv/mpe_fifo.sv
sv/mpe_back.sv
sv/mouse_packet_event_decoder.sv
sv/mpe_checker.sv
sim/mouse_packet_event_decoder_test.sv
